// ----- src/kdl_pkg.sv -----
package kdl_pkg;

    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOCK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_COUNT = 3'd4;

    // lock phases
    localparam logic [1:0] PH_WAIT_FIRST  = 2'd0;
    localparam logic [1:0] PH_WAIT_SECOND = 2'd1;
    localparam logic [1:0] PH_GRANTED     = 2'd2;
    localparam logic [1:0] PH_DENIED      = 2'd3;

    localparam logic [7:0] UNKNOWN_KEY = 8'd63;

    localparam logic [7:0]  RST_FIRST_CODE  = 8'd48;
    localparam logic [7:0]  RST_SECOND_CODE = 8'd53;
    localparam logic [15:0] RST_UNLOCK      = 16'd4000;
    localparam logic [15:0] RST_BLINK_HALF  = 16'd250;
    localparam logic [3:0]  RST_BLINK_COUNT = 4'd8;

    typedef struct packed {
        logic [7:0]  first_code_char;
        logic [7:0]  second_code_char;
        logic [15:0] unlock_ticks;
        logic [15:0] blink_half_ticks;
        logic [3:0]  blink_count;
    } cfg_t;

    typedef struct packed {
        logic       leds_lit;
        logic [7:0] key_char;
        logic [1:0] lock_phase;
    } res_t;

    typedef logic [7:0] key_rom_t [16];

    localparam key_rom_t KEY_ROM = '{
        8'h2A, 8'h30, 8'h23, 8'h44, 8'h37, 8'h38, 8'h39, 8'h43,
        8'h34, 8'h35, 8'h36, 8'h42, 8'h31, 8'h32, 8'h33, 8'h41
    };

    // exactly one key pressed gives its character, anything else '?'
    function automatic logic [7:0] decode_key(input logic [15:0] v);
        logic [3:0] idx;
        logic       single;
        idx = '0;
        single = (v != 16'd0) && ((v & (v - 16'd1)) == 16'd0);
        for (int i = 0; i < 16; i++)
        begin
            if (v[i])
            begin
                idx = 4'(i);
            end
        end
        return single ? KEY_ROM[idx] : UNKNOWN_KEY;
    endfunction

endpackage

// ----- src/kdl_cfg_regs.sv -----
module kdl_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kdl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    output kdl_pkg::cfg_t                  cfg
);
    import kdl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FIRST_CODE:  cfg_next.first_code_char  = cfg_data[7:0];
                REG_SECOND_CODE: cfg_next.second_code_char = cfg_data[7:0];
                REG_UNLOCK:      cfg_next.unlock_ticks     = cfg_data;
                REG_BLINK_HALF:  cfg_next.blink_half_ticks = cfg_data;
                REG_BLINK_COUNT: cfg_next.blink_count      = cfg_data[3:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_code_char  <= RST_FIRST_CODE;
            cfg_reg.second_code_char <= RST_SECOND_CODE;
            cfg_reg.unlock_ticks     <= RST_UNLOCK;
            cfg_reg.blink_half_ticks <= RST_BLINK_HALF;
            cfg_reg.blink_count      <= RST_BLINK_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/kdl_core.sv -----
module kdl_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           command,
    input  logic [15:0]    first_scan,
    input  logic [15:0]    second_scan,
    input  kdl_pkg::cfg_t  cfg,
    output kdl_pkg::res_t  res
);
    import kdl_pkg::*;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic [15:0] tick_reg;
    logic [15:0] tick_next;
    logic [3:0]  blinks_reg;
    logic [3:0]  blinks_next;
    logic        led_reg;
    logic        led_next;

    logic [7:0]  key;
    logic [15:0] tick_inc;
    logic [3:0]  blinks_inc;

    assign tick_inc   = tick_reg + 16'd1;
    assign blinks_inc = blinks_reg + 4'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        tick_next   = tick_reg;
        blinks_next = blinks_reg;
        led_next    = led_reg;
        key         = UNKNOWN_KEY;

        if (!command)
        begin
            key = decode_key(first_scan & second_scan);
            if (key != UNKNOWN_KEY)
            begin
                if (phase_reg == PH_WAIT_FIRST)
                begin
                    held_next  = key;
                    phase_next = PH_WAIT_SECOND;
                end
                else if (phase_reg == PH_WAIT_SECOND)
                begin
                    tick_next   = '0;
                    blinks_next = '0;
                    led_next    = 1'b1;
                    if (held_reg == cfg.first_code_char && key == cfg.second_code_char)
                    begin
                        phase_next = PH_GRANTED;
                    end
                    else
                    begin
                        phase_next = PH_DENIED;
                    end
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_GRANTED:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.unlock_ticks)
                    begin
                        tick_next  = '0;
                        led_next   = 1'b0;
                        phase_next = PH_WAIT_FIRST;
                    end
                end
                PH_DENIED:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.blink_half_ticks)
                    begin
                        tick_next = '0;
                        if (led_reg)
                        begin
                            led_next    = 1'b0;
                            blinks_next = blinks_inc;
                            if (blinks_inc >= cfg.blink_count)
                            begin
                                blinks_next = '0;
                                phase_next  = PH_WAIT_FIRST;
                            end
                        end
                        else
                        begin
                            led_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // ticks are ignored while waiting for keys
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign res.leds_lit   = led_next;
    assign res.key_char   = key;
    assign res.lock_phase = phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT_FIRST;
            held_reg   <= '0;
            tick_reg   <= '0;
            blinks_reg <= '0;
            led_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            tick_reg   <= tick_next;
            blinks_reg <= blinks_next;
            led_reg    <= led_next;
        end
    end

    a_wait_first_exit: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_WAIT_FIRST |=>
            phase_reg == PH_WAIT_FIRST || phase_reg == PH_WAIT_SECOND)
        else $error("phase left first-key wait other than to second-key wait");

    a_dark_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT_FIRST || phase_reg == PH_WAIT_SECOND) |-> !led_reg)
        else $error("leds lit while waiting for keys");

    a_lit_when_granted: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_GRANTED |-> led_reg)
        else $error("leds dark during granted display");

    a_no_move_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(led_reg))
        else $error("lock state moved without an item");

endmodule

// ----- src/keypad_two_digit_code_lock.sv -----
// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------
// sample    | sample_valid, sample_stall | command, first_scan, second_scan
// result    | result_valid, result_stall | leds_lit, key_char, lock_phase
// cfg       | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// one item per cycle sustained while result_stall is low; result_valid rises once an accepted item
// has passed the input register and then the lock update into the result register
// rst_n clears the lock state, the registers to their defaults and empties both stages
// a stalled result holds the input register, which then stalls the sample side
module keypad_two_digit_code_lock (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic                           command,
    input  logic [15:0]                    first_scan,
    input  logic [15:0]                    second_scan,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           leds_lit,
    output logic [7:0]                     key_char,
    output logic [1:0]                     lock_phase,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kdl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data
);
    import kdl_pkg::*;

    cfg_t cfg;
    res_t res;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_cmd_reg;
    logic [15:0] s1_first_reg;
    logic [15:0] s1_second_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    res_t        res_reg;

    logic advance;
    logic accept;
    logic step;

    assign advance      = !res_valid_reg || !result_stall;
    assign sample_stall = s1_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;
    assign step         = s1_valid_reg && advance;

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign res_valid_next = step ? 1'b1 : (advance ? 1'b0 : res_valid_reg);

    kdl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kdl_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .command     (s1_cmd_reg),
        .first_scan  (s1_first_reg),
        .second_scan (s1_second_reg),
        .cfg         (cfg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= command;
            s1_first_reg  <= first_scan;
            s1_second_reg <= second_scan;
        end
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign result_valid = res_valid_reg;
    assign leds_lit     = res_reg.leds_lit;
    assign key_char     = res_reg.key_char;
    assign lock_phase   = res_reg.lock_phase;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import kdl_pkg::*;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // keypad characters, matrix bit 0 in the lowest byte
    localparam logic [127:0] KEY_CHARS = "A321B654C987D#0*";

    typedef struct packed {
        logic        cmd;
        logic [15:0] scan_a;
        logic [15:0] scan_b;
    } sample_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    logic                 command      = 1'b0;
    logic [15:0]          first_scan   = '0;
    logic [15:0]          second_scan  = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic                 leds_lit;
    logic [7:0]           key_char;
    logic [1:0]           lock_phase;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [15:0]          cfg_data     = '0;

    keypad_two_digit_code_lock i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .command      (command),
        .first_scan   (first_scan),
        .second_scan  (second_scan),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .leds_lit     (leds_lit),
        .key_char     (key_char),
        .lock_phase   (lock_phase),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sample_t pending_samples[$];
    res_t    expected_results[$];

    // lock shadow
    cfg_t        lock_cfg  = '{RST_FIRST_CODE, RST_SECOND_CODE, RST_UNLOCK, RST_BLINK_HALF,
                               RST_BLINK_COUNT};
    logic [1:0]  lock_ph   = PH_WAIT_FIRST;
    logic [7:0]  held_char = '0;
    logic [15:0] tick_cnt  = '0;
    logic [3:0]  blinks    = '0;
    logic        led_on    = 1'b0;

    int send_idle_pct   = 37;
    int recv_stall_pct  = 56;
    int hold_left       = 0;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;

    int errors          = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int unlocks         = 0;
    int lockouts        = 0;
    int settings_used   = 0;

    function automatic logic [7:0] key_of(input logic [15:0] v);
        if ($countones(v) != 1)
        begin
            return UNKNOWN_KEY;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (v[i])
            begin
                return KEY_CHARS[8*i +: 8];
            end
        end
        return UNKNOWN_KEY;
    endfunction

    function automatic int key_index(input logic [7:0] ch);
        for (int i = 0; i < 16; i++)
        begin
            if (KEY_CHARS[8*i +: 8] == ch)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic lock_predict(input sample_t s);
        logic [7:0] ch;
        res_t       r;
        ch = UNKNOWN_KEY;
        if (s.cmd == CMD_SAMPLE)
        begin
            ch = key_of(s.scan_a & s.scan_b);
            if (ch != UNKNOWN_KEY)
            begin
                if (lock_ph == PH_WAIT_FIRST)
                begin
                    held_char = ch;
                    lock_ph = PH_WAIT_SECOND;
                end
                else if (lock_ph == PH_WAIT_SECOND)
                begin
                    tick_cnt = '0;
                    blinks = '0;
                    led_on = 1'b1;
                    if (held_char == lock_cfg.first_code_char &&
                        ch == lock_cfg.second_code_char)
                    begin
                        lock_ph = PH_GRANTED;
                        unlocks++;
                    end
                    else
                    begin
                        lock_ph = PH_DENIED;
                        lockouts++;
                    end
                end
            end
        end
        else if (lock_ph == PH_GRANTED)
        begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= lock_cfg.unlock_ticks)
            begin
                tick_cnt = '0;
                led_on = 1'b0;
                lock_ph = PH_WAIT_FIRST;
            end
        end
        else if (lock_ph == PH_DENIED)
        begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= lock_cfg.blink_half_ticks)
            begin
                tick_cnt = '0;
                if (led_on)
                begin
                    led_on = 1'b0;
                    blinks = blinks + 4'd1;
                    if (blinks >= lock_cfg.blink_count)
                    begin
                        blinks = '0;
                        lock_ph = PH_WAIT_FIRST;
                    end
                end
                else
                begin
                    led_on = 1'b1;
                end
            end
        end
        r.leds_lit = led_on;
        r.key_char = ch;
        r.lock_phase = lock_ph;
        expected_results.push_back(r);
    endtask

    // sender
    always @(posedge clk)
    begin : drive_proc
        logic    offer;
        sample_t nxt;
        if (rst_n)
        begin
            offer = sample_valid;
            if (sample_valid && !sample_stall)
            begin
                lock_predict({command, first_scan, second_scan});
                items_accepted++;
                offer = 1'b0;
            end
            if (!offer && pending_samples.size() != 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_samples.pop_front();
                command <= nxt.cmd;
                first_scan <= nxt.scan_a;
                second_scan <= nxt.scan_b;
                offer = 1'b1;
            end
            sample_valid <= offer;
        end
    end

    // long receiver hold-off, started once
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left <= 250;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin : check_proc
        res_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (leds_lit !== want.leds_lit)
                    begin
                        $error("leds_lit: expected %0d, got %0d", want.leds_lit, leds_lit);
                        errors++;
                    end
                    if (key_char !== want.key_char)
                    begin
                        $error("key_char: expected %0d, got %0d", want.key_char, key_char);
                        errors++;
                    end
                    if (lock_phase !== want.lock_phase)
                    begin
                        $error("lock_phase: expected %0d, got %0d", want.lock_phase,
                               lock_phase);
                        errors++;
                    end
                end
            end
            result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic push_key(input logic [7:0] ch);
        int          idx;
        logic [15:0] bit_k;
        logic [15:0] noise;
        logic [15:0] split;
        idx = key_index(ch);
        if (idx < 0)
        begin
            idx = $urandom_range(15);
        end
        bit_k = 16'd1 << idx;
        // bounce bits never survive the and of the two scans
        noise = 16'($urandom) & ~bit_k;
        split = 16'($urandom);
        pending_samples.push_back({CMD_SAMPLE, bit_k | (noise & split),
                                   bit_k | (noise & ~split)});
    endtask

    task automatic push_raw(input logic cmd, input logic [15:0] a, input logic [15:0] b);
        pending_samples.push_back({cmd, a, b});
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            // now and then a stray key press during the display
            if ($urandom_range(99) < 3)
            begin
                push_key(KEY_CHARS[8*$urandom_range(15) +: 8]);
            end
            push_raw(CMD_TICK, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_FIRST_CODE:  lock_cfg.first_code_char = data[7:0];
            REG_SECOND_CODE: lock_cfg.second_code_char = data[7:0];
            REG_UNLOCK:      lock_cfg.unlock_ticks = data;
            REG_BLINK_HALF:  lock_cfg.blink_half_ticks = data;
            REG_BLINK_COUNT: lock_cfg.blink_count = data[3:0];
            default: ;
        endcase
    endtask

    task automatic finish_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] c1, input logic [15:0] c2,
                              input logic [15:0] u, input logic [15:0] h,
                              input logic [15:0] n);
        write_reg(REG_FIRST_CODE, c1);
        write_reg(REG_SECOND_CODE, c2);
        write_reg(REG_UNLOCK, u);
        write_reg(REG_BLINK_HALF, h);
        write_reg(REG_BLINK_COUNT, n);
        settings_used++;
        finish_cfg();
    endtask

    initial
    begin : stimulus
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] k1;
        logic [7:0] k2;
        int         unlock_eff;
        int         half_eff;
        int         count_eff;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: ignored tick, non-keys, then the default code
        push_raw(CMD_TICK, 16'hFFFF, 16'hFFFF);
        push_raw(CMD_SAMPLE, 16'h0000, 16'h0000);
        push_raw(CMD_SAMPLE, 16'hFFFF, 16'hFFFF);
        push_raw(CMD_SAMPLE, 16'hFFFF, 16'h0000);
        push_raw(CMD_SAMPLE, 16'h8001, 16'h8001);
        push_key("0");
        push_key("5");
        push_ticks(3);
        push_key("1");
        wait_idle();
        // unlock time lowered below the running count
        write_reg(REG_UNLOCK, 16'd1);
        finish_cfg();
        push_ticks(2);
        // same key for both digits
        push_key("0");
        push_key("0");
        push_ticks(3);
        wait_idle();
        write_reg(REG_BLINK_HALF, 16'd1);
        write_reg(REG_BLINK_COUNT, 16'd1);
        finish_cfg();
        push_ticks(3);
        wait_idle();

        // zero timing registers behave as one
        set_config(16'h0037, 16'hFF41, 16'd0, 16'd0, 16'd0);
        push_key("7");
        push_key("A");
        push_ticks(2);
        push_key("7");
        push_key("7");
        push_ticks(3);
        wait_idle();

        // code characters that no key produces
        set_config(16'h0000, 16'h00FF, 16'd1, 16'd1, 16'd1);
        push_key("*");
        push_key("#");
        push_ticks(3);
        wait_idle();

        // longest intervals, then cut short
        set_config(16'h002A, 16'h0023, 16'hFFFF, 16'hFFFF, 16'd15);
        push_key("*");
        push_key("#");
        push_ticks(3);
        wait_idle();
        write_reg(REG_UNLOCK, 16'd2);
        finish_cfg();
        push_ticks(2);
        push_key("D");
        push_key("#");
        push_ticks(3);
        wait_idle();
        write_reg(REG_BLINK_HALF, 16'd1);
        finish_cfg();
        push_ticks(32);

        for (int round = 0; round < 9; round++)
        begin
            wait_idle();
            if (round % 3 == 0)
            begin
                case (round / 3)
                    0:
                    begin
                        send_idle_pct <= 37;
                        recv_stall_pct <= 56;
                    end
                    1:
                    begin
                        send_idle_pct <= 56;
                        recv_stall_pct <= 37;
                    end
                    default:
                    begin
                        send_idle_pct <= 0;
                        recv_stall_pct <= 0;
                    end
                endcase
            end
            if (round == 6)
            begin
                hold_req <= 1'b1;
            end
            c1 = ($urandom_range(3) != 0) ? KEY_CHARS[8*$urandom_range(15) +: 8]
                                          : 8'($urandom);
            c2 = ($urandom_range(3) != 0) ? KEY_CHARS[8*$urandom_range(15) +: 8]
                                          : 8'($urandom);
            set_config({8'($urandom), c1}, {8'($urandom), c2},
                       16'($urandom_range(12, 1)), 16'($urandom_range(4, 1)),
                       16'($urandom_range(15, 1)));
            unlock_eff = lock_cfg.unlock_ticks;
            half_eff = lock_cfg.blink_half_ticks;
            count_eff = lock_cfg.blink_count;
            while (pending_samples.size() < 110)
            begin
                if ($urandom_range(99) < 15)
                begin
                    push_raw(1'($urandom), 16'($urandom), 16'($urandom));
                end
                else
                begin
                    k1 = KEY_CHARS[8*$urandom_range(15) +: 8];
                    k2 = KEY_CHARS[8*$urandom_range(15) +: 8];
                    if ($urandom_range(99) < 60 && key_index(lock_cfg.first_code_char) >= 0)
                    begin
                        k1 = lock_cfg.first_code_char;
                    end
                    if ($urandom_range(99) < 60 && key_index(lock_cfg.second_code_char) >= 0)
                    begin
                        k2 = lock_cfg.second_code_char;
                    end
                    push_key(k1);
                    push_key(k2);
                    if (k1 == lock_cfg.first_code_char && k2 == lock_cfg.second_code_char)
                    begin
                        push_ticks(unlock_eff + $urandom_range(2));
                    end
                    else
                    begin
                        push_ticks(2 * half_eff * count_eff + $urandom_range(2));
                    end
                end
            end
        end
        wait_idle();
        repeat (10) @(posedge clk);

        $display("run covered %0d items over %0d register settings: %0d unlocks, %0d lockouts",
                 items_accepted, settings_used, unlocks, lockouts);
        $display("%0d result items compared, %0d mismatches", results_checked, errors);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d result items outstanding", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
